>>> hdl/assert_macros.svh
// Assertion macros for the RTL files; included by lfu_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHK_IMPL(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/lfu_pkg.sv
// Types and constants of the LFU cache policy block
package lfu_pkg;
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int CW          = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam int CNT_W       = 16;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;
    localparam logic [1:0] REG_CAP_ADDR = 2'd0;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] req_key;
        logic signed [31:0] put_value;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
    } t_rsp;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_HIT,
        MODE_INSERT,
        MODE_EVICT
    } t_mode;

    typedef struct packed {
        logic load;
        logic lookup;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } t_dp_sts;
endpackage

>>> hdl/lfu_ctrl.sv
// Sequencer of the LFU cache: accept, lookup, victim scan, commit
module lfu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  lfu_pkg::t_dp_sts i_sts,
    output lfu_pkg::t_dp_cmd o_cmd
);
    import lfu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_SCAN   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = i_sts.need_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.commit) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

>>> hdl/lfu_datapath.sv
// Entry store, lookup, victim scan and update of the LFU cache
`include "assert_macros.svh"
module lfu_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfu_pkg::t_req               i_req,
    input  logic [lfu_pkg::CAP_W-1:0]   i_cap,
    input  lfu_pkg::t_dp_cmd            i_cmd,
    output lfu_pkg::t_dp_sts            o_sts,
    output lfu_pkg::t_rsp               o_rsp
);
    import lfu_pkg::*;

    logic [MAX_ENTRIES-1:0] r_valid;
    logic [31:0]            r_key  [MAX_ENTRIES];
    logic [31:0]            r_val  [MAX_ENTRIES];
    logic [CNT_W-1:0]       r_cnt  [MAX_ENTRIES];
    logic [IDX_W-1:0]       r_rank [MAX_ENTRIES];
    logic [FILL_W-1:0]      r_fill;

    t_req             r_req;
    t_mode            r_mode, mode_c;
    logic [IDX_W-1:0] r_tgt, r_scan, r_best;
    logic             r_best_ok;
    t_rsp             r_rsp;

    logic             any_hit;
    logic [IDX_W-1:0] hit_idx, free_idx, tgt;
    logic [CW-1:0]    cap_x, cap_eff;
    logic             fill_full, better;
    logic [IDX_W-1:0] rt;

    always_comb begin
        any_hit  = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_key[i] == r_req.req_key) begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) free_idx = IDX_W'(i);
        end
    end

    assign cap_x     = CW'(i_cap);
    assign cap_eff   = (cap_x > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_x;
    assign fill_full = CW'(r_fill) >= cap_eff;

    always_comb begin
        if (i_cap == '0)             mode_c = MODE_NONE;
        else if (any_hit)            mode_c = MODE_HIT;
        else if (r_req.cmd == CMD_GET) mode_c = MODE_NONE;
        else if (fill_full)          mode_c = MODE_EVICT;
        else                         mode_c = MODE_INSERT;
    end

    assign better = r_valid[r_scan] &&
        (!r_best_ok || r_cnt[r_scan] < r_cnt[r_best] ||
         (r_cnt[r_scan] == r_cnt[r_best] && r_rank[r_scan] > r_rank[r_best]));

    assign o_sts.need_scan = (mode_c == MODE_EVICT);
    assign o_sts.scan_last = (r_scan == IDX_W'(MAX_ENTRIES - 1));

    assign tgt = (r_mode == MODE_EVICT) ? r_best : r_tgt;
    assign rt  = r_rank[tgt];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.lookup) begin
            r_mode    <= mode_c;
            r_tgt     <= any_hit ? hit_idx : free_idx;
            r_scan    <= '0;
            r_best    <= '0;
            r_best_ok <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_scan <= r_scan + 1'b1;
            if (better) begin
                r_best    <= r_scan;
                r_best_ok <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_rsp.hit        <= (r_mode == MODE_HIT);
            r_rsp.read_value <= (r_mode == MODE_HIT && r_req.cmd == CMD_GET) ?
                                r_val[r_tgt] : MISS_VALUE;
            r_rsp.evicted    <= (r_mode == MODE_EVICT);
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (IDX_W'(i) == tgt) begin
                    if (r_mode == MODE_HIT) begin
                        r_rank[i] <= '0;
                        if (r_cnt[i] != COUNT_MAX) r_cnt[i] <= r_cnt[i] + 1'b1;
                        if (r_req.cmd == CMD_PUT) r_val[i] <= r_req.put_value;
                    end else if (r_mode == MODE_EVICT || r_mode == MODE_INSERT) begin
                        r_rank[i] <= '0;
                        r_cnt[i]  <= CNT_W'(1);
                        r_key[i]  <= r_req.req_key;
                        r_val[i]  <= r_req.put_value;
                    end
                end else if (r_valid[i]) begin
                    if (r_mode == MODE_INSERT) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end else if ((r_mode == MODE_HIT || r_mode == MODE_EVICT) &&
                                 r_rank[i] < rt) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
        end else if (i_cmd.commit && r_mode == MODE_INSERT) begin
            r_valid[tgt] <= 1'b1;
            r_fill       <= r_fill + 1'b1;
        end
    end

    assign o_rsp = r_rsp;

    `CHK_IMPL(a_fill_bound, 1'b1, r_fill <= FILL_W'(MAX_ENTRIES))
    `CHK_NEXT(a_fill_grow, i_cmd.commit && r_mode == MODE_INSERT, r_fill == $past(r_fill) + 1'b1)
    `CHK_NEXT(a_evict_keep, i_cmd.commit && r_mode == MODE_EVICT, $stable(r_fill))
endmodule

>>> hdl/lfu_cache_policy.sv
// Top level of the LFU cache with LRU tie-break and its APB register
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_stall    i_in_data  (t_req)
//  response  out        o_out_valid / i_out_stall  o_out_data (t_rsp)
//  config    in         psel/penable/pwrite        paddr, pwdata, prdata
//
// A hit, a miss or an insert passes through accept, lookup and commit.
// A put that evicts adds a victim scan over all MAX_ENTRIES entries.
// The sequencer works on one request at a time; the commit waits for a free
// output register. Reset clears valid bits and fill count.
module lfu_cache_policy (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lfu_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lfu_pkg::t_rsp  o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [1:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import lfu_pkg::*;

    logic [CAP_W-1:0] r_cap;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && paddr == REG_CAP_ADDR) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CAP_ADDR) ? {{(32 - CAP_W){1'b0}}, r_cap} : '0;

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    lfu_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_data),
        .i_cap   (r_cap),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_rsp   (o_out_data)
    );
endmodule

>>> tb/lfu_cache_policy_test.sv
// Testbench for the LFU cache policy block: directed and randomised requests checked against a local predictor
`timescale 1ns / 100ps
module lfu_cache_policy_test;
    import lfu_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_req        i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_rsp        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lfu_cache_policy i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [4:0]       cap_reg;
    logic             slot_valid [MAX_ENTRIES];
    logic [31:0]      slot_key   [MAX_ENTRIES];
    logic [31:0]      slot_value [MAX_ENTRIES];
    logic [CNT_W-1:0] slot_uses  [MAX_ENTRIES];
    int unsigned      slot_rank  [MAX_ENTRIES];
    int unsigned      fill;

    t_rsp        pending_rsp[$];
    int          mismatches;
    int unsigned cycles;
    logic        out_stall_en;
    logic [31:0] key_pool[8];

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void touch_slot(int s);
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s])
                slot_rank[i]++;
        slot_rank[s] = 0;
        if (slot_uses[s] != COUNT_MAX)
            slot_uses[s]++;
    endfunction

    function automatic t_rsp predict_response(t_req rq);
        t_rsp        r;
        int unsigned c;
        int          found;
        int          slot;
        int          victim;
        r.hit = 1'b0;
        r.read_value = MISS_VALUE;
        r.evicted = 1'b0;
        found = -1;
        slot = -1;
        victim = -1;
        c = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg;
        if (c == 0)
            return r;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == rq.req_key)
                found = i;
        if (found >= 0) begin
            r.hit = 1'b1;
            if (rq.cmd == CMD_GET)
                r.read_value = slot_value[found];
            else
                slot_value[found] = rq.put_value;
            touch_slot(found);
            return r;
        end
        if (rq.cmd == CMD_GET)
            return r;
        if (fill >= c) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                    (slot_uses[i] == slot_uses[victim] && slot_rank[i] > slot_rank[victim])))
                    victim = i;
            end
            if (victim >= 0) begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (slot_valid[i] && slot_rank[i] > slot_rank[victim])
                        slot_rank[i]--;
                slot_valid[victim] = 1'b0;
                fill--;
                r.evicted = 1'b1;
                slot = victim;
            end
        end
        if (slot < 0)
            for (int i = MAX_ENTRIES - 1; i >= 0; i--)
                if (!slot_valid[i])
                    slot = i;
        if (slot < 0)
            return r;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_valid[i])
                slot_rank[i]++;
        slot_valid[slot] = 1'b1;
        slot_key[slot] = rq.req_key;
        slot_value[slot] = rq.put_value;
        slot_uses[slot] = CNT_W'(1);
        slot_rank[slot] = 0;
        fill++;
        return r;
    endfunction

    // response checker and receiver stall
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %h", $time, o_out_data);
                mismatches++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (o_out_data.hit !== exp_rsp.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, exp_rsp.hit,
                             o_out_data.hit);
                    mismatches++;
                end
                if (o_out_data.read_value !== exp_rsp.read_value) begin
                    $display("%0t: read_value expected %h actual %h", $time,
                             exp_rsp.read_value, o_out_data.read_value);
                    mismatches++;
                end
                if (o_out_data.evicted !== exp_rsp.evicted) begin
                    $display("%0t: evicted expected %b actual %b", $time,
                             exp_rsp.evicted, o_out_data.evicted);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!out_stall_en)
            i_out_stall <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            i_out_stall <= 1'b1;
        else if ($urandom_range(0, 2) == 0)
            i_out_stall <= 1'b0;
        else if ($urandom_range(0, 30) == 0)
            i_out_stall <= 1'b0;
    end

    task automatic idle_cycles(int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic random_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return;
        else if (k < 95)
            idle_cycles($urandom_range(1, 3));
        else
            idle_cycles($urandom_range(10, 40));
    endtask

    task automatic send_request(logic cmd, logic [31:0] key, logic [31:0] value);
        t_req rq;
        rq.cmd = cmd;
        rq.req_key = key;
        rq.put_value = value;
        i_in_valid = 1'b1;
        i_in_data = rq;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_rsp.push_back(predict_response(rq));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(negedge i_clk);
        idle_cycles(DRAIN_CYCLES);
    endtask

    task automatic write_capacity(logic [4:0] c);
        wait_drained();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_CAP_ADDR; pwdata <= {27'd0, c};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        cap_reg = c;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic test_directed();
        send_request(CMD_GET, 32'h0000_0000, 32'h0);
        send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_GET, 32'h8000_0000, 32'h1234_5678);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0);
        send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0);
        send_request(CMD_GET, 32'h0000_0005, 32'h0);
        // disabled cache
        write_capacity(5'd0);
        send_request(CMD_PUT, 32'h0000_0011, 32'h55);
        send_request(CMD_GET, 32'h0000_0011, 32'h0);
        send_request(CMD_GET, 32'h8000_0000, 32'h0);
        // oversized capacity
        write_capacity(5'd31);
        for (int i = 0; i < 18; i++)
            send_request(CMD_PUT, 32'h100 + i, 32'hA000 + i);
        // capacity lowered below the fill
        write_capacity(5'd2);
        send_request(CMD_GET, 32'h10A, 32'h0);
        send_request(CMD_PUT, 32'h200, 32'h1);
        send_request(CMD_PUT, 32'h201, 32'h2);
    endtask

    task automatic test_repeated_use();
        write_capacity(5'd1);
        send_request(CMD_PUT, 32'h0000_0042, 32'h9);
        for (int i = 0; i < 40; i++)
            send_request(CMD_GET, 32'h0000_0042, 32'h0);
        send_request(CMD_PUT, 32'h0000_0043, 32'h1);
        send_request(CMD_GET, 32'h0000_0042, 32'h0);
    endtask

    task automatic test_random(int n, logic [4:0] c);
        logic [31:0] key;
        write_capacity(c);
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                key = $urandom();
            else if ($urandom_range(0, 3) == 0)
                key = key_pool[$urandom_range(0, 7)];
            else
                key = $urandom_range(0, 23);
            send_request(1'($urandom_range(0, 1)), key, $urandom());
            random_gap();
        end
    endtask

    initial begin
        mismatches = 0;
        cycles = 0;
        out_stall_en = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cap_reg = CAP_RESET;
        fill = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i] = '0;
            slot_value[i] = '0;
            slot_uses[i] = '0;
            slot_rank[i] = 0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_repeated_use();
        out_stall_en = 1'b1;
        test_random(300, 5'd16);
        test_random(200, 5'd4);
        test_random(150, 5'd1);
        test_random(100, 5'd0);
        test_random(200, 5'd9);
        test_random(200, 5'd20);
        out_stall_en = 1'b0;
        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hdl
hdl/lfu_pkg.sv
hdl/lfu_ctrl.sv
hdl/lfu_datapath.sv
hdl/lfu_cache_policy.sv
tb/lfu_cache_policy_test.sv
